>>> hdl/vpr_pkg.sv
// Shared types, constants and constant tables of the vector plane rotator.
// Used by every vpr_* module and by the vector_plane_rotator top level.
// No dependencies.
package vpr_pkg;

  // Field widths
  localparam int ANGLE_W = 17;
  localparam int COORD_W = 32;
  localparam int TDATA_IN_W = 120;
  localparam int TDATA_OUT_W = 96;

  // CORDIC sizing: x/y carry headroom over Q2.30, z holds a binary angle
  localparam int ROTATION_STAGES = 20;
  localparam int CORD_W = 34;
  localparam int ZANG_W = 33;
  localparam int ATAN_W = 30;
  localparam logic signed [CORD_W-1:0] GAIN_INV_Q30 = 34'sh0_26DD_3B6A;

  // Angle conversion: 46080 units per turn = 2^10 * 45
  localparam int FULL_TURN = 46080;
  localparam int DIV_45 = 45;
  localparam int RECIP_45 = 2982617;        // ceil(2^27 / 45)
  localparam int RECIP_SHIFT = 27;
  localparam int STEP_PER_UNIT = 93206;     // floor(2^22 / 45)

  // Product rounding: half an LSB of the Q2.30 scale
  localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_2000_0000;

  typedef enum logic [1:0] {
    PLANE_XY   = 2'd0,
    PLANE_XZ   = 2'd1,
    PLANE_YZ   = 2'd2,
    PLANE_PASS = 2'd3
  } vpr_plane_t;

  // Vector plus plane selector, carried alongside the angle path
  typedef struct packed {
    vpr_plane_t                 action;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } vpr_item_t;

  // Folded binary angle handed to the CORDIC
  typedef struct packed {
    logic                       flip;
    logic signed [COORD_W-1:0]  phase;
    vpr_item_t                  item;
  } vpr_phase_t;

  // CORDIC result handed to the product stages
  typedef struct packed {
    logic                       flip;
    logic signed [CORD_W-1:0]   cos_v;
    logic signed [CORD_W-1:0]   sin_v;
    vpr_item_t                  item;
  } vpr_trig_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [ATAN_W-1:0] atan_bin(input logic [4:0] idx);
    logic [ATAN_W-1:0] a;
    unique case (idx)
      5'd0:  a = 30'h2000_0000;
      5'd1:  a = 30'h12E4_051E;
      5'd2:  a = 30'h09FB_385B;
      5'd3:  a = 30'h0511_11D4;
      5'd4:  a = 30'h028B_0D43;
      5'd5:  a = 30'h0145_D7E1;
      5'd6:  a = 30'h00A2_F61E;
      5'd7:  a = 30'h0051_7C55;
      5'd8:  a = 30'h0028_BE53;
      5'd9:  a = 30'h0014_5F2F;
      5'd10: a = 30'h000A_2F98;
      5'd11: a = 30'h0005_17CC;
      5'd12: a = 30'h0002_8BE6;
      5'd13: a = 30'h0001_45F3;
      5'd14: a = 30'h0000_A2FA;
      5'd15: a = 30'h0000_517D;
      5'd16: a = 30'h0000_28BE;
      5'd17: a = 30'h0000_145F;
      5'd18: a = 30'h0000_0A30;
      5'd19: a = 30'h0000_0518;
      5'd20: a = 30'h0000_028C;
      5'd21: a = 30'h0000_0146;
      5'd22: a = 30'h0000_00A3;
      5'd23: a = 30'h0000_0051;
      5'd24: a = 30'h0000_0029;
      5'd25: a = 30'h0000_0014;
      5'd26: a = 30'h0000_000A;
      5'd27: a = 30'h0000_0005;
      5'd28: a = 30'h0000_0003;
      5'd29: a = 30'h0000_0001;
      5'd30: a = 30'h0000_0001;
      5'd31: a = 30'h0000_0000;
    endcase
    return a;
  endfunction

  // floor((34*m + 22) / 45): fractional carry of m * 2^22 / 45, rounded
  function automatic logic [5:0] frac_tbl(input logic [5:0] m);
    logic [5:0] f;
    unique case (m)
      6'd0:  f = 6'd0;   6'd1:  f = 6'd1;   6'd2:  f = 6'd2;   6'd3:  f = 6'd2;
      6'd4:  f = 6'd3;   6'd5:  f = 6'd4;   6'd6:  f = 6'd5;   6'd7:  f = 6'd5;
      6'd8:  f = 6'd6;   6'd9:  f = 6'd7;   6'd10: f = 6'd8;   6'd11: f = 6'd8;
      6'd12: f = 6'd9;   6'd13: f = 6'd10;  6'd14: f = 6'd11;  6'd15: f = 6'd11;
      6'd16: f = 6'd12;  6'd17: f = 6'd13;  6'd18: f = 6'd14;  6'd19: f = 6'd14;
      6'd20: f = 6'd15;  6'd21: f = 6'd16;  6'd22: f = 6'd17;  6'd23: f = 6'd17;
      6'd24: f = 6'd18;  6'd25: f = 6'd19;  6'd26: f = 6'd20;  6'd27: f = 6'd20;
      6'd28: f = 6'd21;  6'd29: f = 6'd22;  6'd30: f = 6'd23;  6'd31: f = 6'd23;
      6'd32: f = 6'd24;  6'd33: f = 6'd25;  6'd34: f = 6'd26;  6'd35: f = 6'd26;
      6'd36: f = 6'd27;  6'd37: f = 6'd28;  6'd38: f = 6'd29;  6'd39: f = 6'd29;
      6'd40: f = 6'd30;  6'd41: f = 6'd31;  6'd42: f = 6'd32;  6'd43: f = 6'd32;
      6'd44: f = 6'd33;
      default: f = 6'd0;
    endcase
    return f;
  endfunction

endpackage

>>> hdl/vpr_phase.sv
// Angle front end: 1/128 degree angle to a folded 32-bit binary angle.
// Five register stages: wrap, divide by 45, remainder, fraction, fold.
// Depends on vpr_pkg.
module vpr_phase (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [vpr_pkg::ANGLE_W-1:0]  in_angle,
  input  vpr_pkg::vpr_item_t                  in_item,
  output logic                                out_valid,
  output vpr_pkg::vpr_phase_t                 out_phase
);
  import vpr_pkg::*;

  localparam logic signed [17:0] TURN_S  = 18'(FULL_TURN);
  localparam logic signed [17:0] TURN2_S = 18'(2 * FULL_TURN);
  localparam logic signed [31:0] QTR_POS = 32'sh4000_0000;
  localparam logic signed [31:0] QTR_NEG = 32'shC000_0000;
  localparam logic [31:0]        HALF_TURN = 32'h8000_0000;

  logic [3:0]        v_r;
  logic              out_v_r;
  vpr_item_t         item_r [4];
  logic [15:0]       r_a_r, r_b_r;
  logic [9:0]        q_b_r, q_c_r, q_d_r;
  logic [5:0]        m_c_r;
  logic [22:0]       t_d_r;
  vpr_phase_t        ph_r;

  logic signed [17:0] ang_ext, wrap;
  logic [15:0]        r_a_nxt;
  logic [37:0]        prod_b;
  logic [9:0]         q_b_nxt;
  logic [15:0]        m_full;
  logic [22:0]        t_d_nxt;
  logic [31:0]        ph_sum;
  logic               fold;
  vpr_phase_t         ph_nxt;

  // Stage logic
  always_comb begin
    // reduce the angle into one turn
    ang_ext = 18'(in_angle);
    priority if (ang_ext < -TURN_S) begin
      wrap = ang_ext + TURN2_S;
    end else if (ang_ext < 18'sd0) begin
      wrap = ang_ext + TURN_S;
    end else if (ang_ext >= TURN_S) begin
      wrap = ang_ext - TURN_S;
    end else begin
      wrap = ang_ext;
    end
    r_a_nxt = wrap[15:0];

    // quotient by 45 through the reciprocal
    prod_b  = 38'(r_a_r) * 38'(RECIP_45);
    q_b_nxt = prod_b[RECIP_SHIFT +: 10];

    // remainder
    m_full = r_b_r - 16'(q_b_r) * 16'(DIV_45);

    // remainder's share of the turn: m * 2^22 / 45, rounded
    t_d_nxt = 23'(m_c_r) * 23'(STEP_PER_UNIT) + 23'(frac_tbl(m_c_r));

    // binary angle and fold into +-90 degrees
    ph_sum = {q_d_r, 22'b0} + {9'b0, t_d_r};
    fold   = ($signed(ph_sum) > QTR_POS) || ($signed(ph_sum) < QTR_NEG);
    ph_nxt.flip  = fold;
    ph_nxt.phase = fold ? $signed(ph_sum ^ HALF_TURN) : $signed(ph_sum);
    ph_nxt.item  = item_r[3];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[2:0], in_valid};
      out_v_r <= v_r[3];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      item_r[1] <= item_r[0];
      item_r[2] <= item_r[1];
      item_r[3] <= item_r[2];
      r_a_r     <= r_a_nxt;
      r_b_r     <= r_a_r;
      q_b_r     <= q_b_nxt;
      q_c_r     <= q_b_r;
      m_c_r     <= m_full[5:0];
      q_d_r     <= q_c_r;
      t_d_r     <= t_d_nxt;
      ph_r      <= ph_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_phase = ph_r;

endmodule

>>> hdl/vpr_cordic.sv
// Rotation-mode CORDIC: one register stage per iteration, ROTATION_STAGES deep.
// Produces cosine and sine in Q2.30 with the fold flag carried along.
// Depends on vpr_pkg.
module vpr_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  vpr_pkg::vpr_phase_t  in_phase,
  output logic                 out_valid,
  output vpr_pkg::vpr_trig_t   out_trig
);
  import vpr_pkg::*;

  localparam int N = ROTATION_STAGES;

  logic [N-1:0]               v_r;
  logic                       flip_r [N];
  vpr_item_t                  item_r [N];
  logic signed [CORD_W-1:0]   x_r [N];
  logic signed [CORD_W-1:0]   y_r [N];
  logic signed [ZANG_W-1:0]   z_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stg
    logic                       vp, fp;
    vpr_item_t                  ip;
    logic signed [CORD_W-1:0]   xp, yp, x_nxt, y_nxt;
    logic signed [ZANG_W-1:0]   zp, z_nxt, a_ext;

    // stage inputs: seed for the first, previous stage otherwise
    if (i == 0) begin : g_first
      assign vp = in_valid;
      assign fp = in_phase.flip;
      assign ip = in_phase.item;
      assign xp = GAIN_INV_Q30;
      assign yp = '0;
      assign zp = ZANG_W'(in_phase.phase);
    end else begin : g_next
      assign vp = v_r[i-1];
      assign fp = flip_r[i-1];
      assign ip = item_r[i-1];
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    // micro-rotation toward z = 0
    always_comb begin
      a_ext = $signed({{(ZANG_W-ATAN_W){1'b0}}, atan_bin(5'(i))});
      if (!zp[ZANG_W-1]) begin
        x_nxt = xp - (yp >>> i);
        y_nxt = yp + (xp >>> i);
        z_nxt = zp - a_ext;
      end else begin
        x_nxt = xp + (yp >>> i);
        y_nxt = yp - (xp >>> i);
        z_nxt = zp + a_ext;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i] <= fp;
        item_r[i] <= ip;
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
      end
    end
  end

  assign out_valid      = v_r[N-1];
  assign out_trig.flip  = flip_r[N-1];
  assign out_trig.cos_v = x_r[N-1];
  assign out_trig.sin_v = y_r[N-1];
  assign out_trig.item  = item_r[N-1];

endmodule

>>> hdl/vpr_mix.sv
// Coordinate update: operand select, four 32x32 products, sums, round/saturate.
// Four register stages; the last holds the finished vector.
// Depends on vpr_pkg.
module vpr_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  vpr_pkg::vpr_trig_t  in_trig,
  output logic                out_valid,
  output vpr_pkg::vpr_item_t  out_item
);
  import vpr_pkg::*;

  logic [3:0]                 v_r;
  vpr_item_t                  item_r [3];
  logic signed [COORD_W-1:0]  c_r, s_r, a_r, b_r;
  logic signed [63:0]         p_ca_r, p_sb_r, p_sa_r, p_cb_r;
  logic signed [63:0]         v0_r, v1_r;
  vpr_item_t                  res_r;

  logic signed [CORD_W-1:0]   c_full, s_full;
  logic                       s_neg;
  logic signed [COORD_W-1:0]  c_nxt, s_nxt, a_nxt, b_nxt;
  logic signed [COORD_W-1:0]  r0, r1;
  vpr_item_t                  res_nxt;

  // (v >>> 30) clamped to 32-bit signed
  function automatic logic signed [COORD_W-1:0] sat_q30(input logic signed [63:0] v);
    logic signed [63:0] sh;
    sh = v >>> 30;
    if (sh[63:31] == '0 || sh[63:31] == '1) begin
      return sh[COORD_W-1:0];
    end else if (sh[63]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  // Sign fix-up and operand select
  always_comb begin
    c_full = in_trig.flip ? -in_trig.cos_v : in_trig.cos_v;
    s_neg  = in_trig.flip ^ (in_trig.item.action == PLANE_XZ);
    s_full = s_neg ? -in_trig.sin_v : in_trig.sin_v;
    c_nxt  = c_full[COORD_W-1:0];
    s_nxt  = s_full[COORD_W-1:0];
    unique case (in_trig.item.action)
      PLANE_XY: begin
        a_nxt = in_trig.item.x;
        b_nxt = in_trig.item.y;
      end
      PLANE_XZ: begin
        a_nxt = in_trig.item.x;
        b_nxt = in_trig.item.z;
      end
      PLANE_YZ: begin
        a_nxt = in_trig.item.y;
        b_nxt = in_trig.item.z;
      end
      PLANE_PASS: begin
        a_nxt = '0;
        b_nxt = '0;
      end
    endcase
  end

  // Rounded, saturated results placed back into the vector
  always_comb begin
    r0      = sat_q30(v0_r);
    r1      = sat_q30(v1_r);
    res_nxt = item_r[2];
    unique case (item_r[2].action)
      PLANE_XY: begin
        res_nxt.x = r0;
        res_nxt.y = r1;
      end
      PLANE_XZ: begin
        res_nxt.x = r0;
        res_nxt.z = r1;
      end
      PLANE_YZ: begin
        res_nxt.y = r0;
        res_nxt.z = r1;
      end
      PLANE_PASS: begin
        res_nxt = item_r[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // select
      item_r[0] <= in_trig.item;
      c_r       <= c_nxt;
      s_r       <= s_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      // products
      item_r[1] <= item_r[0];
      p_ca_r    <= c_r * a_r;
      p_sb_r    <= s_r * b_r;
      p_sa_r    <= s_r * a_r;
      p_cb_r    <= c_r * b_r;
      // sums with rounding bias
      item_r[2] <= item_r[1];
      v0_r      <= p_ca_r - p_sb_r + ROUND_HALF;
      v1_r      <= p_sa_r + p_cb_r + ROUND_HALF;
      // result
      res_r     <= res_nxt;
    end
  end

  assign out_valid = v_r[3];
  assign out_item  = res_r;

endmodule

>>> hdl/vector_plane_rotator.sv
// Top level of the vector plane rotator: stream ports, pipeline, output skid.
// Instantiates vpr_phase, vpr_cordic and vpr_mix; depends on vpr_pkg.
//
// Usage:
//   Input beats carry a Q15.16 vector, an angle in 1/128 degree and a plane
//   selector in in_tuser (0 = XY, 1 = XZ, 2 = YZ, 3 = pass through). Each
//   input beat yields exactly one output beat with the rotated, saturated
//   vector, in input order.
//   Pipeline: the accepting edge loads the first of 5 angle, 20 CORDIC, 4 product
//   and 1 output stages, in that order.
//   Throughput: one beat per cycle while in_tready is high; the CORDIC chain
//   and the four 32x32 multipliers are each fully pipelined.
//   Stalls: the whole pipeline advances on one enable. When out_tready is low
//   with a result waiting, the next finished result lands in a one-entry
//   skid register and in_tready drops on the following cycle; it returns as
//   soon as the skid entry moves to the output. in_tready is the inverse of
//   the skid valid register.
//   Reset: rst_n (synchronous, active low) clears every valid bit and the
//   skid entry; no beat is in flight afterwards and in_tready is high.
module vector_plane_rotator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [vpr_pkg::TDATA_IN_W-1:0]        in_tdata,  // angle, in_x, in_y, in_z, 7'b0
  input  logic [1:0]                            in_tuser,  // action
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [vpr_pkg::TDATA_OUT_W-1:0]       out_tdata  // out_x, out_y, out_z
);
  import vpr_pkg::*;

  logic                 pipe_en;
  vpr_item_t            in_item;
  logic                 ph_v;
  vpr_phase_t           ph;
  logic                 trig_v;
  vpr_trig_t            trig;
  logic                 tail_v;
  vpr_item_t            tail;

  logic                 out_v_r, out_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  vpr_item_t            out_r, out_nxt;
  vpr_item_t            skid_r, skid_nxt;
  logic                 take;

  // Unpack the input beat
  always_comb begin
    in_item.action = vpr_plane_t'(in_tuser);
    in_item.x      = $signed(in_tdata[48:17]);
    in_item.y      = $signed(in_tdata[80:49]);
    in_item.z      = $signed(in_tdata[112:81]);
  end

  assign pipe_en   = !skid_v_r;
  assign in_tready = pipe_en;

  vpr_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_tvalid),
    .in_angle  ($signed(in_tdata[ANGLE_W-1:0])),
    .in_item   (in_item),
    .out_valid (ph_v),
    .out_phase (ph)
  );

  vpr_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (ph_v),
    .in_phase  (ph),
    .out_valid (trig_v),
    .out_trig  (trig)
  );

  vpr_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (trig_v),
    .in_trig   (trig),
    .out_valid (tail_v),
    .out_item  (tail)
  );

  // Output register with one-entry skid
  always_comb begin
    take       = out_v_r && out_tready;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (take) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (tail_v) begin
      if (!out_v_r || take) begin
        out_nxt   = tail;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = tail;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.z, out_r.y, out_r.x};

  // The skid entry only exists behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid while output register empty");

  // The skid fills only when the output was stalled
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled without an output stall");

  // A frozen pipeline keeps its finished tail beat
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_en && tail_v) |=> (tail_v && $stable(tail)))
    else $error("tail beat lost or changed while pipeline stalled");

endmodule
